// ===== hw/rtl/mlls_pkg.sv =====
// Package with item types, opcodes and command constants for the memory-LCD line serializer.
package mlls_pkg;

  typedef enum logic [1:0] {
    OpClear = 2'd0,
    OpBegin = 2'd1,
    OpData  = 2'd2,
    OpEnd   = 2'd3
  } op_e;

  localparam logic [7:0] CmdClear = 8'h20;
  localparam logic [7:0] CmdWrite = 8'h80;
  localparam logic [7:0] ByteZero = 8'h00;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] line_address;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic serial_bit;
    logic chip_select;
    logic frame_end;
    logic last;
  } out_item_t;

  // One serializer job: word sent MSB first, short jobs send only the upper byte.
  typedef struct packed {
    logic [15:0] word;
    logic        short_len;
    logic        close;
  } job_t;

endpackage

// ===== hw/rtl/memory_lcd_line_serializer.sv =====
// Top level of the memory-LCD line serializer.
// Path: an accepted item is written to the job queue, then loaded into the shifter, and only
// then is its first bit valid on the output; the shifter may still be busy with an earlier job.
// Throughput: one output bit per cycle while out_ready_i is high; an item sends 16 bits, 8 for a
// data byte, from the one-bit shifter; items dropped outside a frame send none.
// The front end keeps accepting while the QueueDepth-entry job queue has room.
// Reset clears the frame flag, the queue and the shifter; no frame is open after reset.
module memory_lcd_line_serializer #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mlls_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mlls_pkg::out_item_t out_item_o
);
  import mlls_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_job, pop_job;

  mlls_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_item_i,
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  mlls_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  mlls_back u_back (
    .clk_i,
    .rst_ni,
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_job_i    (pop_job),
    .out_valid_o,
    .out_ready_i,
    .out_item_o
  );

  a_frame_end_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.frame_end |-> out_item_o.last)
    else $error("frame_end without last");

  a_idle_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_item_o.last && !pop_valid |=> !out_valid_o)
    else $error("output valid with no job left");

  a_load_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && pop_valid |=> out_valid_o)
    else $error("queued job not loaded");

endmodule

// ===== hw/rtl/mlls_front.sv =====
// Front end: accepts items, tracks the open frame and turns items into serializer jobs.
module mlls_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mlls_pkg::in_item_t in_item_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output mlls_pkg::job_t    push_job_o
);
  import mlls_pkg::*;

  logic       frame_open_q, frame_open_d;
  logic       accept;
  logic [7:0] addr_rev;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      addr_rev[i] = in_item_i.line_address[7-i];
    end
  end

  always_comb begin
    frame_open_d          = frame_open_q;
    push_valid_o          = 1'b0;
    push_job_o.word       = {ByteZero, ByteZero};
    push_job_o.short_len  = 1'b0;
    push_job_o.close      = 1'b0;
    unique case (op_e'(in_item_i.opcode))
      OpClear: begin
        push_valid_o     = accept;
        push_job_o.word  = {CmdClear, ByteZero};
        push_job_o.close = 1'b1;
        frame_open_d     = 1'b0;
      end
      OpBegin: begin
        push_valid_o    = accept;
        push_job_o.word = {CmdWrite, addr_rev};
        frame_open_d    = 1'b1;
      end
      OpData: begin
        push_valid_o         = accept && frame_open_q;
        push_job_o.word      = {in_item_i.data_byte, ByteZero};
        push_job_o.short_len = 1'b1;
      end
      OpEnd: begin
        push_valid_o     = accept && frame_open_q;
        push_job_o.close = 1'b1;
        frame_open_d     = 1'b0;
      end
      default: begin
        push_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
    end else if (accept) begin
      frame_open_q <= frame_open_d;
    end
  end

endmodule

// ===== hw/rtl/mlls_fifo.sv =====
// Job queue between front end and serializer.
module mlls_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  mlls_pkg::job_t push_job_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output mlls_pkg::job_t pop_job_o
);
  import mlls_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/mlls_back.sv =====
// Back end: shifts each job out one bit per item on the output channel.
module mlls_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  mlls_pkg::job_t     pop_job_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mlls_pkg::out_item_t out_item_o
);
  import mlls_pkg::*;

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] word_q, word_d;
  logic        close_q, close_d;
  logic        last_bit;
  logic        load;

  assign last_bit    = (cnt_q == 5'd1);
  assign pop_ready_o = !busy_q || (out_ready_i && last_bit);
  assign load        = pop_valid_i && pop_ready_o;

  assign out_valid_o            = busy_q;
  assign out_item_o.serial_bit  = word_q[15];
  assign out_item_o.chip_select = 1'b1;
  assign out_item_o.last        = last_bit;
  assign out_item_o.frame_end   = last_bit && close_q;

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    word_d  = word_q;
    close_d = close_q;
    if (load) begin
      busy_d  = 1'b1;
      cnt_d   = pop_job_i.short_len ? 5'd8 : 5'd16;
      word_d  = pop_job_i.word;
      close_d = pop_job_i.close;
    end else if (busy_q && out_ready_i) begin
      // advance
      busy_d = !last_bit;
      cnt_d  = cnt_q - 5'd1;
      word_d = {word_q[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    close_q <= close_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule
